// ===== design/lfu_pkg.sv =====
// Shared types and constants of the LFU cache table.
package lfu_pkg;

   localparam int KEY_W   = 32;
   localparam int VALUE_W = 32;
   localparam int CSR_W   = 5;

   // Capacity register value after reset.
   localparam logic [CSR_W-1:0]   CSR_CAPACITY_RESET = 5'd16;
   // Value returned by a get that misses.
   localparam logic [VALUE_W-1:0] MISS_VALUE = {VALUE_W{1'b1}};

   // Request kinds carried in req_tuser.
   localparam logic CMD_GET = 1'b0;
   localparam logic CMD_PUT = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_DECIDE,
      ST_VICTIM
   } lfu_state_type;

   // Table update and result that the controller asks the datapath to commit.
   typedef enum logic [2:0] {
      CMT_NONE,
      CMT_GET_MISS,
      CMT_GET_HIT,
      CMT_PUT_SKIP,
      CMT_PUT_HIT,
      CMT_PUT_FREE,
      CMT_PUT_EVICT
   } lfu_commit_type;

   typedef struct packed {
      logic           capture;
      logic           lookup;
      lfu_commit_type commit;
   } lfu_cmd_type;

   typedef struct packed {
      logic is_put;
      logic hit;
      logic lim_zero;
      logic full;
      logic out_free;
   } lfu_status_type;

endpackage

// ===== design/lfu_cache_table_core.sv =====
// Top level of the LFU cache table: controller, datapath and victim search tree.
//
// Key-value cache of CAPACITY entries with least-frequently-used replacement and a
// least-recently-used tie break. Each request carries a get or a put; a get returns the
// stored value with hit high, or all ones with hit low on a miss, and raises the entry's
// use count; a put overwrites a present key or inserts a new one, evicting among the
// entries with the lowest count the one touched least recently when the table holds
// csr_capacity entries. Counts saturate at their maximum, a capacity of zero turns puts
// into pure presence checks, and values above CAPACITY act as CAPACITY. The table is
// empty after reset and needs no clearing pass. Requests are taken one at a time: a get,
// a put to a present key and a put into a free slot pass through transfer, key match
// with the value memory read, and commit; a put that evicts waits before its commit
// for the registered tree that searches for the victim to settle through its depth.
// A finished result waits in the response register while the next request is taken.
module lfu_cache_table_core #(
   parameter int CAPACITY  = 16,
   parameter int FREQ_BITS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   // Request channel.
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [2*lfu_pkg::KEY_W-1:0] req_tdata,  // lookup_key [31:0], write_value [63:32]
   input  logic [0:0]                  req_tuser,  // command [0]: 0 get, 1 put
   // Capacity register.
   input  logic                        csr_wr_en,
   input  logic [lfu_pkg::CSR_W-1:0]   csr_wr_data,
   // Response channel.
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [lfu_pkg::VALUE_W-1:0] rsp_tdata,  // read_value [31:0]
   output logic [1:0]                  rsp_tuser   // hit [0], evicted [1]
);

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);

   lfu_pkg::lfu_cmd_type    cmd;
   lfu_pkg::lfu_status_type status;

   logic [CAPACITY-1:0]  entry_valid;
   logic [FREQ_BITS-1:0] entry_freq [CAPACITY];
   logic [IDX_W-1:0]     entry_rank [CAPACITY];
   logic                 victim_valid;
   logic [IDX_W-1:0]     victim_idx;
   logic [IDX_W-1:0]     victim_rank;

   // The victim tree has IDX_W register levels; the controller waits in ST_VICTIM until they
   // have settled, so that its root reflects the table after the previous commit.
   lfu_ctrl #(
      .WAIT_CYCLES (IDX_W)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .status     (status),
      .req_tready (req_tready),
      .cmd        (cmd)
   );

   lfu_datapath #(
      .CAPACITY  (CAPACITY),
      .FREQ_BITS (FREQ_BITS),
      .IDX_W     (IDX_W),
      .CNT_W     (CNT_W)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .req_tdata    (req_tdata),
      .req_tuser    (req_tuser),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .rsp_tready   (rsp_tready),
      .cmd          (cmd),
      .victim_valid (victim_valid),
      .victim_idx   (victim_idx),
      .victim_rank  (victim_rank),
      .status       (status),
      .entry_valid  (entry_valid),
      .entry_freq   (entry_freq),
      .entry_rank   (entry_rank),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tdata    (rsp_tdata),
      .rsp_tuser    (rsp_tuser)
   );

   lfu_victim_tree #(
      .CAPACITY  (CAPACITY),
      .FREQ_BITS (FREQ_BITS),
      .IDX_W     (IDX_W)
   ) u_victim_tree (
      .clock        (clock),
      .entry_valid  (entry_valid),
      .entry_freq   (entry_freq),
      .entry_rank   (entry_rank),
      .victim_valid (victim_valid),
      .victim_idx   (victim_idx),
      .victim_rank  (victim_rank)
   );

endmodule

// ===== design/lfu_ctrl.sv =====
// Controller state machine of the LFU cache table.
module lfu_ctrl #(
   parameter int WAIT_CYCLES = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  lfu_pkg::lfu_status_type status,
   output logic                   req_tready,
   output lfu_pkg::lfu_cmd_type    cmd
);

   localparam int WAIT_W = $clog2(WAIT_CYCLES + 1);

   lfu_pkg::lfu_state_type state_ff, state_in;
   logic [WAIT_W-1:0]      wait_ff, wait_in;
   lfu_pkg::lfu_commit_type decide_commit;

   // Commit chosen at the end of the lookup; CMT_NONE means the victim search must run.
   always_comb begin
      if (!status.is_put) begin
         decide_commit = status.hit ? lfu_pkg::CMT_GET_HIT : lfu_pkg::CMT_GET_MISS;
      end else if (status.lim_zero) begin
         decide_commit = lfu_pkg::CMT_PUT_SKIP;
      end else if (status.hit) begin
         decide_commit = lfu_pkg::CMT_PUT_HIT;
      end else if (status.full) begin
         decide_commit = lfu_pkg::CMT_NONE;
      end else begin
         decide_commit = lfu_pkg::CMT_PUT_FREE;
      end
   end

   always_comb begin
      state_in = state_ff;
      wait_in  = wait_ff;
      unique case (state_ff)
         lfu_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               state_in = lfu_pkg::ST_LOOKUP;
            end
         end
         lfu_pkg::ST_LOOKUP: begin
            state_in = lfu_pkg::ST_DECIDE;
         end
         lfu_pkg::ST_DECIDE: begin
            if (decide_commit == lfu_pkg::CMT_NONE) begin
               state_in = lfu_pkg::ST_VICTIM;
               wait_in  = WAIT_W'(WAIT_CYCLES);
            end else if (status.out_free) begin
               state_in = lfu_pkg::ST_IDLE;
            end
         end
         lfu_pkg::ST_VICTIM: begin
            if (wait_ff != '0) begin
               wait_in = wait_ff - 1'b1;
            end else if (status.out_free) begin
               state_in = lfu_pkg::ST_IDLE;
            end
         end
         default: state_in = lfu_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready  = 1'b0;
      cmd.capture = 1'b0;
      cmd.lookup  = 1'b0;
      cmd.commit  = lfu_pkg::CMT_NONE;
      unique case (state_ff)
         lfu_pkg::ST_IDLE: begin
            req_tready  = 1'b1;
            cmd.capture = req_tvalid;
         end
         lfu_pkg::ST_LOOKUP: begin
            cmd.lookup = 1'b1;
         end
         lfu_pkg::ST_DECIDE: begin
            if (status.out_free) begin
               cmd.commit = decide_commit;
            end
         end
         lfu_pkg::ST_VICTIM: begin
            if (wait_ff == '0 && status.out_free) begin
               cmd.commit = lfu_pkg::CMT_PUT_EVICT;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lfu_pkg::ST_IDLE;
         wait_ff  <= '0;
      end else begin
         state_ff <= state_in;
         wait_ff  <= wait_in;
      end
   end

endmodule

// ===== design/lfu_victim_tree.sv =====
// Registered tournament tree that finds the eviction victim among the table entries.
module lfu_victim_tree #(
   parameter int CAPACITY  = 16,
   parameter int FREQ_BITS = 16,
   parameter int IDX_W     = 4
) (
   input  logic                 clock,
   input  logic [CAPACITY-1:0]  entry_valid,
   input  logic [FREQ_BITS-1:0] entry_freq [CAPACITY],
   input  logic [IDX_W-1:0]     entry_rank [CAPACITY],
   output logic                 victim_valid,
   output logic [IDX_W-1:0]     victim_idx,
   output logic [IDX_W-1:0]     victim_rank
);

   localparam int LEAVES = 1 << IDX_W;

   typedef struct packed {
      logic                 vld;
      logic [FREQ_BITS-1:0] freq;
      logic [IDX_W-1:0]     rank;
      logic [IDX_W-1:0]     idx;
   } node_type;

   // Lower count wins; on equal counts the older entry (higher rank) wins.
   function automatic node_type pick(input node_type a, input node_type b);
      node_type res;
      if (!b.vld) begin
         res = a;
      end else if (!a.vld) begin
         res = b;
      end else if (b.freq < a.freq || (b.freq == a.freq && b.rank > a.rank)) begin
         res = b;
      end else begin
         res = a;
      end
      return res;
   endfunction

   node_type leaf [LEAVES];
   node_type node_ff [1:LEAVES-1];

   for (genvar j = 0; j < LEAVES; j++) begin : g_leaf
      if (j < CAPACITY) begin : g_used
         assign leaf[j] = '{vld: entry_valid[j], freq: entry_freq[j],
                            rank: entry_rank[j], idx: IDX_W'(j)};
      end else begin : g_pad
         assign leaf[j] = '0;
      end
   end

   // Heap numbering: node k has children 2k and 2k+1; indexes at or above LEAVES are leaves.
   for (genvar k = 1; k < LEAVES; k++) begin : g_node
      if (2 * k >= LEAVES) begin : g_bottom
         always_ff @(posedge clock) begin
            node_ff[k] <= pick(leaf[2*k-LEAVES], leaf[2*k+1-LEAVES]);
         end
      end else begin : g_inner
         always_ff @(posedge clock) begin
            node_ff[k] <= pick(node_ff[2*k], node_ff[2*k+1]);
         end
      end
   end

   assign victim_valid = node_ff[1].vld;
   assign victim_idx   = node_ff[1].idx;
   assign victim_rank  = node_ff[1].rank;

endmodule

// ===== design/lfu_datapath.sv =====
// Datapath of the LFU cache table: key lanes, value memory, counts, ranks and result register.
module lfu_datapath #(
   parameter int CAPACITY  = 16,
   parameter int FREQ_BITS = 16,
   parameter int IDX_W     = 4,
   parameter int CNT_W     = 5
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [2*lfu_pkg::KEY_W-1:0]   req_tdata,
   input  logic [0:0]                    req_tuser,
   input  logic                          csr_wr_en,
   input  logic [lfu_pkg::CSR_W-1:0]     csr_wr_data,
   input  logic                          rsp_tready,
   input  lfu_pkg::lfu_cmd_type          cmd,
   input  logic                          victim_valid,
   input  logic [IDX_W-1:0]              victim_idx,
   input  logic [IDX_W-1:0]              victim_rank,
   output lfu_pkg::lfu_status_type       status,
   output logic [CAPACITY-1:0]           entry_valid,
   output logic [FREQ_BITS-1:0]          entry_freq [CAPACITY],
   output logic [IDX_W-1:0]              entry_rank [CAPACITY],
   output logic                          rsp_tvalid,
   output logic [lfu_pkg::VALUE_W-1:0]   rsp_tdata,
   output logic [1:0]                    rsp_tuser
);

   localparam int LIM_W = (CNT_W > lfu_pkg::CSR_W) ? CNT_W : lfu_pkg::CSR_W;
   localparam logic [FREQ_BITS-1:0] FREQ_MAX = {FREQ_BITS{1'b1}};
   localparam logic [FREQ_BITS-1:0] FREQ_ONE = FREQ_BITS'(1);

   logic [lfu_pkg::CSR_W-1:0]   csr_capacity_ff;
   logic                        req_cmd_ff;
   logic [lfu_pkg::KEY_W-1:0]   req_key_ff;
   logic [lfu_pkg::VALUE_W-1:0] req_value_ff;

   logic [CAPACITY-1:0]         valid_ff;
   logic [lfu_pkg::KEY_W-1:0]   key_ff  [CAPACITY];
   logic [FREQ_BITS-1:0]        freq_ff [CAPACITY];
   logic [IDX_W-1:0]            rank_ff [CAPACITY];
   logic [CNT_W-1:0]            used_ff;

   logic [lfu_pkg::VALUE_W-1:0] value_mem [CAPACITY];
   logic [lfu_pkg::VALUE_W-1:0] rdata_ff;

   logic                        hit_ff;
   logic [IDX_W-1:0]            hit_idx_ff;
   logic [IDX_W-1:0]            hit_rank_ff;

   logic                        rsp_valid_ff;
   logic [lfu_pkg::VALUE_W-1:0] rsp_value_ff;
   logic                        rsp_hit_ff;
   logic                        rsp_evicted_ff;

   logic [CAPACITY-1:0]         hit_vec;
   logic [IDX_W-1:0]            hit_idx;
   logic [IDX_W-1:0]            hit_rank;
   logic [IDX_W-1:0]            free_idx;
   logic [LIM_W-1:0]            lim;

   logic [IDX_W-1:0]            tgt_idx;
   logic [IDX_W-1:0]            tgt_rank;
   logic                        do_touch;
   logic                        do_shift_all;
   logic                        do_bump;
   logic                        do_new;
   logic                        do_write_value;
   logic [lfu_pkg::VALUE_W-1:0] result_value;

   // Key match across all lanes; valid keys are unique, so the hit vector has at most one bit set.
   always_comb begin
      hit_idx  = '0;
      hit_rank = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         hit_vec[i] = valid_ff[i] && (key_ff[i] == req_key_ff);
         if (hit_vec[i]) begin
            hit_idx  = hit_idx | IDX_W'(i);
            hit_rank = hit_rank | rank_ff[i];
         end
      end
   end

   // Lowest-numbered free slot.
   always_comb begin
      free_idx = '0;
      for (int i = CAPACITY - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_idx = IDX_W'(i);
         end
      end
   end

   // Limits above the table size act as the table size.
   always_comb begin
      if (LIM_W'(csr_capacity_ff) > LIM_W'(CAPACITY)) begin
         lim = LIM_W'(CAPACITY);
      end else begin
         lim = LIM_W'(csr_capacity_ff);
      end
   end

   always_comb begin
      tgt_idx        = hit_idx_ff;
      tgt_rank       = hit_rank_ff;
      do_touch       = 1'b0;
      do_shift_all   = 1'b0;
      do_bump        = 1'b0;
      do_new         = 1'b0;
      do_write_value = 1'b0;
      result_value   = '0;
      unique case (cmd.commit)
         lfu_pkg::CMT_NONE, lfu_pkg::CMT_PUT_SKIP: ;
         lfu_pkg::CMT_GET_MISS: begin
            result_value = lfu_pkg::MISS_VALUE;
         end
         lfu_pkg::CMT_GET_HIT: begin
            result_value = rdata_ff;
            do_touch     = 1'b1;
            do_bump      = 1'b1;
         end
         lfu_pkg::CMT_PUT_HIT: begin
            do_touch       = 1'b1;
            do_bump        = 1'b1;
            do_write_value = 1'b1;
         end
         lfu_pkg::CMT_PUT_FREE: begin
            tgt_idx        = free_idx;
            do_shift_all   = 1'b1;
            do_new         = 1'b1;
            do_write_value = 1'b1;
         end
         lfu_pkg::CMT_PUT_EVICT: begin
            // Removing the victim and inserting into its slot ages exactly the
            // entries that were more recent than the victim.
            tgt_idx        = victim_idx;
            tgt_rank       = victim_rank;
            do_touch       = 1'b1;
            do_new         = 1'b1;
            do_write_value = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_capacity_ff <= lfu_pkg::CSR_CAPACITY_RESET;
      end else if (csr_wr_en) begin
         csr_capacity_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_cmd_ff   <= req_tuser[0];
         req_key_ff   <= req_tdata[lfu_pkg::KEY_W-1:0];
         req_value_ff <= req_tdata[2*lfu_pkg::KEY_W-1:lfu_pkg::KEY_W];
      end
      if (cmd.lookup) begin
         hit_ff      <= |hit_vec;
         hit_idx_ff  <= hit_idx;
         hit_rank_ff <= hit_rank;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.lookup) begin
         rdata_ff <= value_mem[hit_idx];
      end
      if (do_write_value) begin
         value_mem[tgt_idx] <= req_value_ff;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < CAPACITY; i++) begin
         if (do_new && tgt_idx == IDX_W'(i)) begin
            key_ff[i] <= req_key_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         used_ff  <= '0;
         for (int i = 0; i < CAPACITY; i++) begin
            freq_ff[i] <= '0;
            rank_ff[i] <= '0;
         end
      end else begin
         if (do_shift_all) begin
            used_ff <= used_ff + 1'b1;
         end
         for (int i = 0; i < CAPACITY; i++) begin
            if (tgt_idx == IDX_W'(i) && (do_touch || do_shift_all)) begin
               rank_ff[i] <= '0;
               if (do_new) begin
                  valid_ff[i] <= 1'b1;
                  freq_ff[i]  <= FREQ_ONE;
               end else if (do_bump && freq_ff[i] != FREQ_MAX) begin
                  freq_ff[i] <= freq_ff[i] + 1'b1;
               end
            end else if (valid_ff[i]) begin
               if (do_shift_all || (do_touch && rank_ff[i] < tgt_rank)) begin
                  rank_ff[i] <= rank_ff[i] + 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit != lfu_pkg::CMT_NONE) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit != lfu_pkg::CMT_NONE) begin
         rsp_value_ff   <= result_value;
         rsp_hit_ff     <= hit_ff;
         rsp_evicted_ff <= (cmd.commit == lfu_pkg::CMT_PUT_EVICT) && victim_valid;
      end
   end

   assign status.is_put   = (req_cmd_ff == lfu_pkg::CMD_PUT);
   assign status.hit      = hit_ff;
   assign status.lim_zero = (csr_capacity_ff == '0);
   assign status.full     = (LIM_W'(used_ff) >= lim);
   assign status.out_free = !rsp_valid_ff || rsp_tready;

   assign entry_valid = valid_ff;
   assign entry_freq  = freq_ff;
   assign entry_rank  = rank_ff;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_value_ff;
   assign rsp_tuser  = {rsp_evicted_ff, rsp_hit_ff};

endmodule

// ===== design/lfu_checker.sv =====
// Port-level assertions for the LFU cache table, bound to its top level.
module lfu_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_tvalid,
   input logic                        req_tready,
   input logic                        rsp_tvalid,
   input logic                        rsp_tready,
   input logic [lfu_pkg::VALUE_W-1:0] rsp_tdata,
   input logic [1:0]                  rsp_tuser
);

   // A stalled response keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   // An eviction only happens for a key that was not present.
   a_evict_miss: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> !rsp_tuser[0])
      else $error("eviction reported together with a hit");

   // Requests are processed one at a time: the block is busy after a transfer.
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while the previous one is in progress");

   // No response is pending right after reset.
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("response valid right after reset");

endmodule

bind lfu_cache_table_core lfu_checker u_lfu_checker (.*);
